FILE: rtl/wbss_pkg.sv
package wbss_pkg;

  // default configuration of the scan unit
  localparam int MAX_PATTERN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // fixed field widths
  localparam int BYTE_W     = 8;
  localparam int REG_W      = 64;
  localparam int LEN_W      = 5;
  localparam int OFFSET_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int SIG_BYTES  = 16;

  // wildcard signature byte (not a wildcard in the first position)
  localparam logic [BYTE_W-1:0] WILDCARD = 8'hCC;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

endpackage

FILE: rtl/wbss_channels.sv
interface wbss_in_if;
  logic                         valid;
  logic                         ready;
  logic [wbss_pkg::BYTE_W-1:0]  data_byte;
  logic                         last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbss_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [wbss_pkg::OFFSET_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

FILE: rtl/wildcard_byte_signature_scan_unit.sv
// Wildcard byte signature scan unit.
// byte_in carries the bytes of a memory region, one item per byte, with
// last_byte set on the final byte. result carries at most one item per region:
// found = 1 with the start offset of the first match, or found = 0 (offset 0)
// on the last byte when nothing matched. Bytes after a match are dropped
// until the region ends. A signature byte of 0xCC is a wildcard except in
// the first position.
// The signature is loaded through the write port (cfg_we, cfg_index,
// cfg_data) while the unit is idle: index 0 holds bytes 0..7, index 1 holds
// bytes 8..15, index 2 the length (0 acts as 1, above MAX_PATTERN as
// MAX_PATTERN).
// Each accepted byte passes one input register, then the window compare and
// offset subtract into the result register. One byte is taken every cycle
// while result is not stalled; the parallel window compare sets this rate.
// When result stalls, the result register holds and the input register
// still takes one more byte; byte_in.ready drops only when both are full.
// Synchronous reset clears the handshake state, the region counter and the
// match flag, and loads the length register with 1 and the signature with 0.
module wildcard_byte_signature_scan_unit #(
  parameter int MAX_PATTERN = wbss_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = wbss_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  wbss_in_if.sink                          byte_in,
  wbss_out_if.source                       result,
  input  logic                             cfg_we,
  input  logic [wbss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wbss_pkg::REG_W-1:0]       cfg_data
);

  localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int EXT_W     = (OFFSET_BITS > wbss_pkg::OFFSET_W) ? OFFSET_BITS
                                                                : wbss_pkg::OFFSET_W;
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  // configuration registers
  logic [wbss_pkg::REG_W-1:0]  pattern_low;
  logic [wbss_pkg::REG_W-1:0]  pattern_high;
  logic [wbss_pkg::LEN_W-1:0]  pattern_length;

  // input register
  logic                        s1_valid;
  logic [wbss_pkg::BYTE_W-1:0] s1_byte;
  logic                        s1_last;

  // region state
  logic [wbss_pkg::BYTE_W-1:0] window [MAX_PATTERN];
  logic [wbss_pkg::BYTE_W-1:0] window_next [MAX_PATTERN];
  logic [OFFSET_BITS-1:0]      count;
  logic [OFFSET_BITS-1:0]      count_next;
  logic                        matched;

  // result register
  logic                         out_valid;
  logic                         out_found;
  logic [wbss_pkg::OFFSET_W-1:0] out_offset;

  logic                         advance;
  logic [wbss_pkg::LEN_W-1:0]   len_eff;
  logic [wbss_pkg::LEN_W-1:0]   len_m1;
  logic [2*wbss_pkg::REG_W-1:0] pattern_all;
  logic [wbss_pkg::LEN_W-1:0]   pos;
  logic [wbss_pkg::BYTE_W-1:0]  sig;
  logic [MAX_PATTERN-1:0]       miss;
  logic                         full_window;
  logic                         hit;
  logic [OFFSET_BITS-1:0]       start;
  logic [EXT_W-1:0]             start_ext;

  // second stage moves whenever the result register is free or being taken
  assign advance       = !out_valid || result.ready;
  assign byte_in.ready = !s1_valid || advance;

  assign result.valid        = out_valid;
  assign result.found        = out_found;
  assign result.match_offset = out_offset;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= wbss_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        wbss_pkg::REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        wbss_pkg::REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        wbss_pkg::REG_PATTERN_LEN:  pattern_length <= cfg_data[wbss_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp length to 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = wbss_pkg::LEN_W'(1);
    end else if (pattern_length > wbss_pkg::LEN_W'(MAX_PATTERN)) begin
      len_eff = wbss_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
  end

  assign len_m1      = len_eff - wbss_pkg::LEN_W'(1);
  assign pattern_all = {pattern_high, pattern_low};

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      s1_byte <= byte_in.data_byte;
      s1_last <= byte_in.last_byte;
    end
  end

  // window after shifting in the new byte, entry 0 newest
  always_comb begin
    window_next[0] = s1_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_next[k] = window[k-1];
    end
  end

  // signature byte j lines up with window entry len-1-j
  always_comb begin
    pos = '0;
    sig = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pos = len_m1 - wbss_pkg::LEN_W'(j);
      sig = pattern_all[wbss_pkg::BYTE_W*j +: wbss_pkg::BYTE_W];
      miss[j] = (wbss_pkg::LEN_W'(j) < len_eff)
             && !((j != 0) && (sig == wbss_pkg::WILDCARD))
             && (window_next[pos[WIN_IDX_W-1:0]] != sig);
    end
  end

  assign full_window = count >= OFFSET_BITS'(len_m1);
  assign hit         = !matched && full_window && (miss == '0);
  assign start       = count - OFFSET_BITS'(len_m1);
  assign start_ext   = EXT_W'(start);
  assign count_next  = (count < COUNT_MAX) ? count + OFFSET_BITS'(1) : count;

  // region state, updated once per byte leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      matched <= 1'b0;
    end else if (s1_valid && advance) begin
      if (s1_last) begin
        count   <= '0;
        matched <= 1'b0;
      end else begin
        count   <= count_next;
        matched <= matched || hit;
      end
    end
  end

  // window contents before a full window are never compared, so no reset
  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && (hit || (s1_last && !matched));
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_found  <= hit;
      out_offset <= hit ? start_ext[wbss_pkg::OFFSET_W-1:0] : '0;
    end
  end

  // a not-found item always carries offset zero
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_offset == '0))
    else $error("not-found result with nonzero offset");

  // no further result inside a region once it has matched
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && matched && !s1_last) |=> !out_valid)
    else $error("second result in a matched region");

  // region end clears the counter and match flag
  a_region_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && s1_last) |=> (count == '0 && !matched))
    else $error("region state not cleared at region end");

  // an empty input register always takes a byte
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> byte_in.ready)
    else $error("input stalled with empty input register");

endmodule
